### rtl/abq_pkg.sv
// ----------------------------------------------------------------------------
// abq_pkg
// Types, constants and helpers shared by the axial billboard quad generator.
// ----------------------------------------------------------------------------
package abq_pkg;

  localparam int HALF_WIDTH_W  = 20;
  localparam int TRAIL_SCALE_W = 18;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 32;
  localparam int VS_W          = 31;
  localparam int SIDE_W        = 22;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [HALF_WIDTH_W-1:0]  HALF_WIDTH_RESET  = 20'd32768;
  localparam logic [TRAIL_SCALE_W-1:0] TRAIL_SCALE_RESET = 18'd16384;

  localparam logic [CFG_INDEX_W-1:0] REG_HALF_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TRAIL_SCALE = 2'd1;

  localparam logic [1:0] CORNER_TAIL_POS = 2'd0;
  localparam logic [1:0] CORNER_HEAD_POS = 2'd1;
  localparam logic [1:0] CORNER_HEAD_NEG = 2'd2;
  localparam logic [1:0] CORNER_TAIL_NEG = 2'd3;

  typedef logic signed [31:0] coord_t;
  typedef logic signed [SIDE_W-1:0] side_t;

  typedef struct packed {
    coord_t head_x;
    coord_t head_y;
    coord_t head_z;
    coord_t vel_x;
    coord_t vel_y;
    coord_t vel_z;
    coord_t cam_x;
    coord_t cam_y;
    coord_t cam_z;
  } in_word_t;

  typedef struct packed {
    coord_t     vert_x;
    coord_t     vert_y;
    coord_t     vert_z;
    logic [1:0] corner;
    logic       last_corner;
  } out_word_t;

  typedef struct packed {
    logic [2:0][31:0]     head;
    logic [2:0][31:0]     tail;
    logic [2:0][31:0]     cam;
    logic [2:0][VS_W-1:0] vs;
  } seg_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LOOK, S_CROSS, S_CMAX, S_FITR, S_MMAX, S_FITL, S_SQ, S_SQRT, S_DIV, S_DONE
  } side_state_t;

  typedef enum logic [1:0] {
    B_IDLE, B_HEAD, B_TAIL, B_EMIT
  } back_state_t;

  function automatic coord_t sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) return 32'sh7fffffff;
    if (v < -36'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

### rtl/abq_front.sv
// ----------------------------------------------------------------------------
// abq_front
// Accepts segments, forms the tail point and the pre-scaled velocity.
// ----------------------------------------------------------------------------
module abq_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  abq_pkg::in_word_t                   in_data,
  input  logic [abq_pkg::TRAIL_SCALE_W-1:0]   trail_scale,
  output logic                                push_valid,
  input  logic                                push_full,
  output abq_pkg::seg_t                       push_data
);

  logic                    s1_valid_r;
  abq_pkg::in_word_t       s1_in_r;
  logic signed [50:0]      s1_prod_r [3];
  logic signed [50:0]      prod [3];
  logic signed [31:0]      vel_in [3];
  logic signed [31:0]      head [3];
  logic signed [31:0]      vel [3];
  logic signed [31:0]      cam [3];
  logic signed [50:0]      rnd [3];
  logic signed [35:0]      diff [3];
  logic [32:0]             vmag [3];
  logic [32:0]             vmax;
  logic [1:0]              vk;
  logic signed [31:0]      vsh [3];

  assign vel_in[0] = in_data.vel_x;
  assign vel_in[1] = in_data.vel_y;
  assign vel_in[2] = in_data.vel_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i] = $signed({1'b0, trail_scale}) * vel_in[i];
    end
  end

  assign in_stall   = s1_valid_r & push_full;
  assign push_valid = s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_in_r <= in_data;
      for (int i = 0; i < 3; i++) begin
        s1_prod_r[i] <= prod[i];
      end
    end
  end

  assign head[0] = s1_in_r.head_x;
  assign head[1] = s1_in_r.head_y;
  assign head[2] = s1_in_r.head_z;
  assign vel[0]  = s1_in_r.vel_x;
  assign vel[1]  = s1_in_r.vel_y;
  assign vel[2]  = s1_in_r.vel_z;
  assign cam[0]  = s1_in_r.cam_x;
  assign cam[1]  = s1_in_r.cam_y;
  assign cam[2]  = s1_in_r.cam_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i]  = s1_prod_r[i] + 51'sd32768;
      diff[i] = $signed({{4{head[i][31]}}, head[i]})
              - $signed({rnd[i][50], rnd[i][50:16]});
      vmag[i] = vel[i][31] ? 33'(-$signed({vel[i][31], vel[i]})) : {1'b0, vel[i]};
    end
    vmax = vmag[0];
    if (vmag[1] > vmax) vmax = vmag[1];
    if (vmag[2] > vmax) vmax = vmag[2];
    if (vmax < 33'h040000000) begin
      vk = 2'd0;
    end else if (vmax < 33'h080000000) begin
      vk = 2'd1;
    end else begin
      vk = 2'd2;
    end
    for (int i = 0; i < 3; i++) begin
      vsh[i] = vel[i] >>> vk;
      push_data.head[i] = head[i];
      push_data.tail[i] = abq_pkg::sat32(diff[i]);
      push_data.cam[i]  = cam[i];
      push_data.vs[i]   = vsh[i][abq_pkg::VS_W-1:0];
    end
  end

endmodule

### rtl/abq_queue.sv
// ----------------------------------------------------------------------------
// abq_queue
// Short queue of prepared segments between the front and the back.
// ----------------------------------------------------------------------------
module abq_queue #(
  parameter int DEPTH = abq_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_full,
  input  abq_pkg::seg_t push_data,
  output logic          pop_valid,
  input  logic          pop,
  output abq_pkg::seg_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  abq_pkg::seg_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign push_full = (count_r == CNT_W'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign do_push   = push_valid & ~push_full;
  assign do_pop    = pop & pop_valid;
  assign pop_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### rtl/abq_side.sv
// ----------------------------------------------------------------------------
// abq_side
// Sequential side-vector unit: cross product, normalization, square root and
// division; cross product, squares and quotient numerators share one multiplier.
// ----------------------------------------------------------------------------
module abq_side (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [2:0][31:0]                   point,
  input  logic [2:0][31:0]                   cam,
  input  logic [2:0][abq_pkg::VS_W-1:0]      vs,
  input  logic [abq_pkg::HALF_WIDTH_W-1:0]   half_width,
  output logic                               done,
  output abq_pkg::side_t                     side [3]
);

  abq_pkg::side_state_t state_r, state_nxt;

  logic [4:0]          cnt_r;
  logic [1:0]          idx_r;
  logic signed [32:0]  d_r [3];
  logic signed [30:0]  l_r [3];
  logic signed [30:0]  vs_r [3];
  logic signed [61:0]  c_r [3];
  logic [61:0]         m_r;
  logic signed [63:0]  prod_r;
  logic [62:0]         sq_r;
  logic [63:0]         n_r, r_r, b_r;
  logic [32:0]         rem_r;
  logic [20:0]         qd_r;
  abq_pkg::side_t      side_r [3];

  logic [61:0]         cm [3];
  logic [61:0]         cmax;
  logic [32:0]         dm [3];
  logic [32:0]         dmax;
  logic [1:0]          dk;
  logic signed [32:0]  dsh [3];
  logic signed [31:0]  mul_a, mul_b;
  logic signed [63:0]  prod;
  logic [2:0]          acc_sel;
  logic [63:0]         rb;
  logic [52:0]         num;
  logic [32:0]         den;
  logic [33:0]         trial;
  logic                ge;
  logic [20:0]         qd_next;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cm[i] = c_r[i][61] ? 62'(-c_r[i]) : 62'(c_r[i]);
      dm[i] = d_r[i][32] ? 33'(-d_r[i]) : 33'(d_r[i]);
    end
    cmax = cm[0];
    if (cm[1] > cmax) cmax = cm[1];
    if (cm[2] > cmax) cmax = cm[2];
    dmax = dm[0];
    if (dm[1] > dmax) dmax = dm[1];
    if (dm[2] > dmax) dmax = dm[2];
    if (dmax < 33'h040000000) begin
      dk = 2'd0;
    end else if (dmax < 33'h080000000) begin
      dk = 2'd1;
    end else if (dmax < 33'h100000000) begin
      dk = 2'd2;
    end else begin
      dk = 2'd3;
    end
    for (int i = 0; i < 3; i++) begin
      dsh[i] = d_r[i] >>> dk;
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      abq_pkg::S_CROSS: begin
        unique case (cnt_r)
          5'd0:    begin mul_a = 32'(l_r[1]); mul_b = 32'(vs_r[2]); end
          5'd1:    begin mul_a = 32'(l_r[2]); mul_b = 32'(vs_r[1]); end
          5'd2:    begin mul_a = 32'(l_r[2]); mul_b = 32'(vs_r[0]); end
          5'd3:    begin mul_a = 32'(l_r[0]); mul_b = 32'(vs_r[2]); end
          5'd4:    begin mul_a = 32'(l_r[0]); mul_b = 32'(vs_r[1]); end
          5'd5:    begin mul_a = 32'(l_r[1]); mul_b = 32'(vs_r[0]); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      abq_pkg::S_SQ: begin
        if (cnt_r < 5'd3) begin
          mul_a = $signed({1'b0, cm[cnt_r[1:0]][30:0]});
          mul_b = mul_a;
        end
      end
      abq_pkg::S_DIV: begin
        mul_a = $signed({1'b0, cm[idx_r][30:0]});
        mul_b = $signed({12'd0, half_width});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign acc_sel = cnt_r[2:0] - 3'd1;
  assign rb      = r_r + b_r;
  assign num     = {1'b0, prod_r[50:0], 1'b0} + {21'd0, r_r[31:0]};
  assign den     = {r_r[31:0], 1'b0};
  assign trial   = {rem_r, qd_r[20]};
  assign ge      = (trial >= {1'b0, den});
  assign qd_next = {qd_r[19:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= abq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      abq_pkg::S_IDLE, abq_pkg::S_DONE: begin
        state_nxt = start ? abq_pkg::S_LOOK : abq_pkg::S_IDLE;
      end
      abq_pkg::S_LOOK:  state_nxt = abq_pkg::S_CROSS;
      abq_pkg::S_CROSS: if (cnt_r == 5'd6) state_nxt = abq_pkg::S_CMAX;
      abq_pkg::S_CMAX:  state_nxt = (cmax == '0) ? abq_pkg::S_DONE : abq_pkg::S_FITR;
      abq_pkg::S_FITR:  if (m_r < 62'h40000000) state_nxt = abq_pkg::S_MMAX;
      abq_pkg::S_MMAX:  state_nxt = abq_pkg::S_FITL;
      abq_pkg::S_FITL:  if (m_r >= 62'h20000000) state_nxt = abq_pkg::S_SQ;
      abq_pkg::S_SQ:    if (cnt_r == 5'd3) state_nxt = abq_pkg::S_SQRT;
      abq_pkg::S_SQRT:  if (b_r == '0) state_nxt = abq_pkg::S_DIV;
      abq_pkg::S_DIV:   if (cnt_r == 5'd22 && idx_r == 2'd2) state_nxt = abq_pkg::S_DONE;
      default:          state_nxt = abq_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      abq_pkg::S_IDLE, abq_pkg::S_DONE: begin
        if (start) begin
          for (int i = 0; i < 3; i++) begin
            d_r[i]  <= $signed({point[i][31], point[i]}) - $signed({cam[i][31], cam[i]});
            vs_r[i] <= $signed(vs[i]);
            c_r[i]  <= '0;
          end
          cnt_r <= '0;
        end
      end
      abq_pkg::S_LOOK: begin
        for (int i = 0; i < 3; i++) begin
          l_r[i] <= dsh[i][30:0];
        end
      end
      abq_pkg::S_CROSS: begin
        prod_r <= prod;
        if (cnt_r != 5'd0) begin
          if (acc_sel[0]) begin
            c_r[acc_sel[2:1]] <= c_r[acc_sel[2:1]] - prod_r[61:0];
          end else begin
            c_r[acc_sel[2:1]] <= c_r[acc_sel[2:1]] + prod_r[61:0];
          end
        end
        cnt_r <= cnt_r + 5'd1;
      end
      abq_pkg::S_CMAX: begin
        m_r <= cmax;
        for (int i = 0; i < 3; i++) begin
          side_r[i] <= '0;
        end
      end
      abq_pkg::S_FITR: begin
        if (m_r >= 62'h40000000) begin
          for (int i = 0; i < 3; i++) begin
            c_r[i] <= c_r[i] >>> 1;
          end
          m_r <= m_r >> 1;
        end
      end
      abq_pkg::S_MMAX: begin
        m_r <= cmax;
      end
      abq_pkg::S_FITL: begin
        if (m_r < 62'h20000000) begin
          for (int i = 0; i < 3; i++) begin
            c_r[i] <= c_r[i] <<< 1;
          end
          m_r <= m_r << 1;
        end else begin
          cnt_r <= '0;
          sq_r  <= '0;
        end
      end
      abq_pkg::S_SQ: begin
        prod_r <= prod;
        if (cnt_r == 5'd3) begin
          n_r <= {1'b0, sq_r + prod_r[62:0]};
          r_r <= '0;
          b_r <= 64'h4000000000000000;
        end else if (cnt_r != 5'd0) begin
          sq_r <= sq_r + prod_r[62:0];
        end
        cnt_r <= cnt_r + 5'd1;
      end
      abq_pkg::S_SQRT: begin
        if (b_r != '0) begin
          if (n_r >= rb) begin
            n_r <= n_r - rb;
            r_r <= (r_r >> 1) + b_r;
          end else begin
            r_r <= r_r >> 1;
          end
          b_r <= b_r >> 2;
        end else begin
          cnt_r <= '0;
          idx_r <= '0;
        end
      end
      abq_pkg::S_DIV: begin
        if (cnt_r == 5'd0) begin
          prod_r <= prod;
          cnt_r  <= cnt_r + 5'd1;
        end else if (cnt_r == 5'd1) begin
          rem_r <= {1'b0, num[52:21]};
          qd_r  <= num[20:0];
          cnt_r <= cnt_r + 5'd1;
        end else begin
          rem_r <= ge ? 33'(trial - {1'b0, den}) : trial[32:0];
          qd_r  <= qd_next;
          if (cnt_r == 5'd22) begin
            side_r[idx_r] <= c_r[idx_r][61] ? -$signed({1'b0, qd_next})
                                            : $signed({1'b0, qd_next});
            idx_r <= idx_r + 2'd1;
            cnt_r <= '0;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign done = (state_r == abq_pkg::S_DONE);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      side[i] = side_r[i];
    end
  end

endmodule

### rtl/abq_back.sv
// ----------------------------------------------------------------------------
// abq_back
// Takes prepared segments from the queue, computes both side vectors and
// sends out the four corner words.
// ----------------------------------------------------------------------------
module abq_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               pop_valid,
  output logic                               pop,
  input  abq_pkg::seg_t                      pop_data,
  input  logic [abq_pkg::HALF_WIDTH_W-1:0]   half_width,
  output logic                               out_valid,
  input  logic                               out_stall,
  output abq_pkg::out_word_t                 out_data
);

  abq_pkg::back_state_t state_r, state_nxt;

  abq_pkg::seg_t      seg_r;
  abq_pkg::side_t     sh_r [3];
  abq_pkg::side_t     st_r [3];
  abq_pkg::side_t     side [3];
  logic [1:0]         k_r;
  logic               out_valid_r;
  abq_pkg::out_word_t out_r;

  logic               side_start, side_done, out_free, use_tail;
  logic [2:0][31:0]   side_point, side_cam;
  logic [2:0][abq_pkg::VS_W-1:0] side_vs;
  abq_pkg::coord_t    vert [3];

  assign out_free   = ~out_valid_r | ~out_stall;
  assign pop        = (state_r == abq_pkg::B_IDLE) & pop_valid;
  assign side_start = pop | ((state_r == abq_pkg::B_HEAD) & side_done);
  assign side_point = (state_r == abq_pkg::B_IDLE) ? pop_data.head : seg_r.tail;
  assign side_cam   = (state_r == abq_pkg::B_IDLE) ? pop_data.cam : seg_r.cam;
  assign side_vs    = (state_r == abq_pkg::B_IDLE) ? pop_data.vs : seg_r.vs;

  abq_side u_side (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (side_start),
    .point      (side_point),
    .cam        (side_cam),
    .vs         (side_vs),
    .half_width (half_width),
    .done       (side_done),
    .side       (side)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= abq_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_free) begin
        out_valid_r <= (state_r == abq_pkg::B_EMIT);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      abq_pkg::B_IDLE: if (pop_valid) state_nxt = abq_pkg::B_HEAD;
      abq_pkg::B_HEAD: if (side_done) state_nxt = abq_pkg::B_TAIL;
      abq_pkg::B_TAIL: if (side_done) state_nxt = abq_pkg::B_EMIT;
      abq_pkg::B_EMIT: begin
        if (out_free && k_r == abq_pkg::CORNER_TAIL_NEG) begin
          state_nxt = abq_pkg::B_IDLE;
        end
      end
      default: state_nxt = abq_pkg::B_IDLE;
    endcase
  end

  assign use_tail = (k_r == abq_pkg::CORNER_TAIL_POS) | (k_r == abq_pkg::CORNER_TAIL_NEG);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [35:0] p36, s36;
      p36 = use_tail ? $signed({{4{seg_r.tail[i][31]}}, seg_r.tail[i]})
                     : $signed({{4{seg_r.head[i][31]}}, seg_r.head[i]});
      s36 = use_tail ? 36'(st_r[i]) : 36'(sh_r[i]);
      vert[i] = abq_pkg::sat32(k_r[1] ? p36 - s36 : p36 + s36);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      seg_r <= pop_data;
    end
    if (state_r == abq_pkg::B_HEAD && side_done) begin
      for (int i = 0; i < 3; i++) begin
        sh_r[i] <= side[i];
      end
    end
    if (state_r == abq_pkg::B_TAIL && side_done) begin
      for (int i = 0; i < 3; i++) begin
        st_r[i] <= side[i];
      end
      k_r <= abq_pkg::CORNER_TAIL_POS;
    end
    if (state_r == abq_pkg::B_EMIT && out_free) begin
      out_r.vert_x      <= vert[0];
      out_r.vert_y      <= vert[1];
      out_r.vert_z      <= vert[2];
      out_r.corner      <= k_r;
      out_r.last_corner <= (k_r == abq_pkg::CORNER_TAIL_NEG);
      k_r               <= k_r + 2'd1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### rtl/axial_billboard_quad_gen.sv
// ----------------------------------------------------------------------------
// axial_billboard_quad_gen
// Camera-facing quad generator for beam segments, signed Q16.16 coordinates.
// ----------------------------------------------------------------------------
// Each accepted segment word yields four corner words in the order tail plus
// side, head plus side, head minus side, tail minus side. The front stage forms
// the tail in one register stage and places the segment in a short queue, so
// new words are taken while an earlier segment is still being worked on. The
// back end runs one side-vector unit twice per segment, and that unit sets the
// rate: a shared 32 by 32 multiplier, a one-bit-per-cycle square root of 32
// steps and three 21-step restoring divisions. The four corner words of a
// segment follow its two side vectors. A zero cross product ends the side
// computation early.
module axial_billboard_quad_gen #(
  parameter int QUEUE_DEPTH = abq_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  abq_pkg::in_word_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output abq_pkg::out_word_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [abq_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [abq_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [abq_pkg::HALF_WIDTH_W-1:0]  half_width_r;
  logic [abq_pkg::TRAIL_SCALE_W-1:0] trail_scale_r;

  logic          push_valid, push_full, pop_valid, pop;
  abq_pkg::seg_t push_data, pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_width_r  <= abq_pkg::HALF_WIDTH_RESET;
      trail_scale_r <= abq_pkg::TRAIL_SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == abq_pkg::REG_HALF_WIDTH) begin
        half_width_r <= cfg_data[abq_pkg::HALF_WIDTH_W-1:0];
      end else if (cfg_index == abq_pkg::REG_TRAIL_SCALE) begin
        trail_scale_r <= cfg_data[abq_pkg::TRAIL_SCALE_W-1:0];
      end
    end
  end

  abq_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .trail_scale (trail_scale_r),
    .push_valid  (push_valid),
    .push_full   (push_full),
    .push_data   (push_data)
  );

  abq_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_full  (push_full),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_data   (pop_data)
  );

  abq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_data   (pop_data),
    .half_width (half_width_r),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the axial billboard quad generator.
// ----------------------------------------------------------------------------
// Beam segment words are sent through the stalled input channel and every
// corner word is compared with a quad computed by an in-bench fixed-point
// model. A short table of directed segments is followed by random segments
// under several half width and trail scale settings, with random gaps on both
// channels and one long hold-off of the corner channel.
// ----------------------------------------------------------------------------
module tb_top;
  import abq_pkg::*;

  localparam int N_RANDOM    = 380;
  localparam int CYCLE_LIMIT = 8000000;

  typedef longint vec_t [3];

  typedef struct {
    in_word_t seg;
    bit       at_rest;
  } seg_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  in_word_t               in_data;
  logic                   out_valid;
  logic                   out_stall;
  out_word_t              out_data;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  logic [HALF_WIDTH_W-1:0]  cur_half_width;
  logic [TRAIL_SCALE_W-1:0] cur_trail_scale;

  out_word_t corner_q[$];
  int        n_segments;
  int        n_corners;
  int        n_mismatch;
  int        n_cycles;
  bit        hold_req;
  seg_row_t  seg_table[$];

  axial_billboard_quad_gen uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint sat_coord(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint largest_mag(vec_t v);
    longint m;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      if ((v[i] < 0 ? -v[i] : v[i]) > m) m = (v[i] < 0 ? -v[i] : v[i]);
    end
    return m;
  endfunction

  function automatic vec_t shrink_below_2p30(vec_t v);
    longint m;
    int     k;
    vec_t   r;
    m = largest_mag(v);
    k = 0;
    while ((m >>> k) >= 64'sd1073741824) k++;
    for (int i = 0; i < 3; i++) r[i] = v[i] >>> k;
    return r;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic vec_t side_offset(vec_t p, vec_t cam, vec_t vs);
    vec_t            l, c, s;
    longint          m;
    longint unsigned sq, len, q, a;
    for (int i = 0; i < 3; i++) l[i] = p[i] - cam[i];
    l = shrink_below_2p30(l);
    c[0] = l[1] * vs[2] - l[2] * vs[1];
    c[1] = l[2] * vs[0] - l[0] * vs[2];
    c[2] = l[0] * vs[1] - l[1] * vs[0];
    for (int i = 0; i < 3; i++) s[i] = 0;
    if (largest_mag(c) == 0) return s;
    c = shrink_below_2p30(c);
    m = largest_mag(c);
    while (m < 64'sd536870912) begin
      for (int i = 0; i < 3; i++) c[i] = c[i] * 2;
      m = m * 2;
    end
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      a = (c[i] < 0) ? -c[i] : c[i];
      sq += a * a;
    end
    len = int_sqrt(sq);
    for (int i = 0; i < 3; i++) begin
      a = (c[i] < 0) ? -c[i] : c[i];
      q = (2 * a * longint'(cur_half_width) + len) / (2 * len);
      s[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
    end
    return s;
  endfunction

  function automatic void predict_quad(in_word_t w);
    vec_t      head, vel, cam, tail, vs, sh, st;
    longint    off;
    out_word_t v;
    head = '{longint'(w.head_x), longint'(w.head_y), longint'(w.head_z)};
    vel  = '{longint'(w.vel_x), longint'(w.vel_y), longint'(w.vel_z)};
    cam  = '{longint'(w.cam_x), longint'(w.cam_y), longint'(w.cam_z)};
    for (int i = 0; i < 3; i++) begin
      off = (longint'(cur_trail_scale) * vel[i] + 32768) >>> 16;
      tail[i] = sat_coord(head[i] - off);
    end
    vs = shrink_below_2p30(vel);
    sh = side_offset(head, cam, vs);
    st = side_offset(tail, cam, vs);
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 3; i++) begin
        longint pt, sd, r;
        pt = (k == 0 || k == 3) ? tail[i] : head[i];
        sd = (k == 0 || k == 3) ? st[i] : sh[i];
        r = sat_coord(k < 2 ? pt + sd : pt - sd);
        if (i == 0) v.vert_x = r[31:0];
        else if (i == 1) v.vert_y = r[31:0];
        else v.vert_z = r[31:0];
      end
      v.corner = k[1:0];
      v.last_corner = (k == 3);
      corner_q.push_back(v);
    end
  endfunction

  function automatic in_word_t mk_seg(int hx, int hy, int hz, int vx, int vy, int vz,
                                      int cx, int cy, int cz);
    in_word_t w;
    w.head_x = hx; w.head_y = hy; w.head_z = hz;
    w.vel_x = vx; w.vel_y = vy; w.vel_z = vz;
    w.cam_x = cx; w.cam_y = cy; w.cam_z = cz;
    return w;
  endfunction

  function automatic int pick_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom;
    if (r < 8) return int'($urandom_range(0, 2097152)) - 1048576;
    if (r == 8) return ($urandom_range(0, 1) == 1) ? 32'sh7fffffff : 32'sh80000000;
    return 0;
  endfunction

  function automatic in_word_t random_seg();
    in_word_t w;
    int       r, t;
    w = mk_seg(pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord(),
               pick_coord(), pick_coord(), pick_coord(), pick_coord());
    r = $urandom_range(0, 9);
    if (r == 0) begin
      w.vel_x = 0; w.vel_y = 0; w.vel_z = 0;
    end else if (r == 1) begin
      t = $urandom_range(0, 7) - 4;
      w.head_x = $signed(int'($urandom_range(0, 65535))) - 32768;
      w.head_y = $signed(int'($urandom_range(0, 65535))) - 32768;
      w.head_z = $signed(int'($urandom_range(0, 65535))) - 32768;
      w.vel_x = $signed(int'($urandom_range(0, 65535))) - 32768;
      w.vel_y = $signed(int'($urandom_range(0, 65535))) - 32768;
      w.vel_z = $signed(int'($urandom_range(0, 65535))) - 32768;
      w.cam_x = w.head_x + t * w.vel_x;
      w.cam_y = w.head_y + t * w.vel_y;
      w.cam_z = w.head_z + t * w.vel_z;
    end
    return w;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 19) return $urandom_range(1, 4);
    return $urandom_range(20, 400);
  endfunction

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_HALF_WIDTH) cur_half_width = val[HALF_WIDTH_W-1:0];
    else if (idx == REG_TRAIL_SCALE) cur_trail_scale = val[TRAIL_SCALE_W-1:0];
  endtask

  task automatic send_seg(in_word_t w, bit at_rest);
    out_word_t v;
    int        gap;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    n_segments++;
    if (at_rest) begin
      // With no velocity the tail is the head and both side offsets vanish.
      for (int k = 0; k < 4; k++) begin
        v.vert_x = w.head_x; v.vert_y = w.head_y; v.vert_z = w.head_z;
        v.corner = k[1:0];
        v.last_corner = (k == 3);
        corner_q.push_back(v);
      end
    end else begin
      predict_quad(w);
    end
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (corner_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) send_seg(random_seg(), 1'b0);
    drain();
  endtask

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      n_corners++;
      if (corner_q.size() == 0) begin
        $error("corner word with no quad pending: %p", out_data);
        n_mismatch++;
      end else begin
        e = corner_q.pop_front();
        if (out_data.vert_x !== e.vert_x) begin
          $error("vert_x expected %0d actual %0d", e.vert_x, out_data.vert_x);
          n_mismatch++;
        end
        if (out_data.vert_y !== e.vert_y) begin
          $error("vert_y expected %0d actual %0d", e.vert_y, out_data.vert_y);
          n_mismatch++;
        end
        if (out_data.vert_z !== e.vert_z) begin
          $error("vert_z expected %0d actual %0d", e.vert_z, out_data.vert_z);
          n_mismatch++;
        end
        if (out_data.corner !== e.corner) begin
          $error("corner expected %0d actual %0d", e.corner, out_data.corner);
          n_mismatch++;
        end
        if (out_data.last_corner !== e.last_corner) begin
          $error("last_corner expected %0d actual %0d", e.last_corner,
                 out_data.last_corner);
          n_mismatch++;
        end
      end
    end
  end

  // Receiver: mostly short stalls, a few long ones, and one long hold-off on request.
  initial begin
    int r, n;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        n = 0;
        while (n < 3000) begin
          @(posedge clk);
          n++;
        end
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 19);
        if (r < 10) out_stall <= 1'b0;
        else if (r < 19) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 3)) @(posedge clk);
          out_stall <= 1'b0;
        end else begin
          out_stall <= 1'b1;
          repeat ($urandom_range(20, 300)) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  initial begin
    n_segments = 0;
    n_corners = 0;
    n_mismatch = 0;
    n_cycles = 0;
    hold_req = 1'b0;
    cur_half_width = HALF_WIDTH_RESET;
    cur_trail_scale = TRAIL_SCALE_RESET;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;

    seg_table = '{
      '{mk_seg(0, 0, 0, 0, 0, 0, 65536, 0, 0), 1'b1},
      '{mk_seg(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 0,
               32'sh80000000, 0, 32'sh80000000), 1'b1},
      '{mk_seg(32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0, 0,
               32'sh7fffffff, 32'sh7fffffff, 0), 1'b1},
      '{mk_seg(32'sh7fffffff, 32'sh80000000, -1, 0, 0, 0, 0, 0, 0), 1'b1},
      '{mk_seg(0, 0, 0, 65536, 0, 0, 0, 0, 65536), 1'b0},
      '{mk_seg(0, 0, 0, 65536, 0, 0, 131072, 0, 0), 1'b0},
      '{mk_seg(65536, 65536, 65536, 65536, 65536, 65536, 0, 0, 0), 1'b0},
      '{mk_seg(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
               32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0, 0), 1'b0},
      '{mk_seg(32'sh80000000, 32'sh80000000, 32'sh80000000,
               32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 0), 1'b0},
      '{mk_seg(32'sh80000000, 0, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 1,
               32'sh7fffffff, 32'sh80000000, 32'sh80000000), 1'b0},
      '{mk_seg(0, 0, 0, 1, 0, 0, 0, 1, 0), 1'b0},
      '{mk_seg(0, 0, 0, -1, -1, -1, -1, 0, 1), 1'b0},
      '{mk_seg(1000, -2000, 3000, 32'sh7fffffff, 1, 0, 0, 0, 32'sh7fffffff), 1'b0},
      '{mk_seg(0, 0, 0, 0, 0, 5, 3, 4, 100), 1'b0}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (seg_table[i]) send_seg(seg_table[i].seg, seg_table[i].at_rest);
    drain();

    write_reg(REG_HALF_WIDTH, 32'hffffffff);
    write_reg(REG_TRAIL_SCALE, 32'hffffffff);
    foreach (seg_table[i]) send_seg(seg_table[i].seg, seg_table[i].at_rest);
    random_phase(60);

    write_reg(REG_HALF_WIDTH, 32'h0);
    write_reg(REG_TRAIL_SCALE, 32'h0);
    random_phase(40);

    write_reg(REG_HALF_WIDTH, $urandom);
    write_reg(REG_TRAIL_SCALE, $urandom);
    write_reg(2'd2, $urandom);
    write_reg(2'd3, $urandom);
    hold_req = 1'b1;
    random_phase(120);

    write_reg(REG_HALF_WIDTH, HALF_WIDTH_RESET);
    write_reg(REG_TRAIL_SCALE, TRAIL_SCALE_RESET);
    random_phase(80);

    write_reg(REG_HALF_WIDTH, $urandom_range(1, 16));
    write_reg(REG_TRAIL_SCALE, $urandom_range(65536, 262143));
    random_phase(N_RANDOM - 300);

    $display("Sent %0d segments under six register settings, checked %0d corner words.",
             n_segments, n_corners);
    $display("Mismatches: %0d", n_mismatch);
    if (n_mismatch == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/abq_pkg.sv
rtl/abq_front.sv
rtl/abq_queue.sv
rtl/abq_side.sv
rtl/abq_back.sv
rtl/axial_billboard_quad_gen.sv
tb/tb_top.sv
